// File: hw/rtl/ubx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser package
// Shared types and constants for the frame parser, its queue and output stage.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam int unsigned UBX_QDEPTH = 4;
  localparam int unsigned UBX_QPTR_W = $clog2(UBX_QDEPTH);
  localparam int unsigned UBX_QCNT_W = UBX_QPTR_W + 1;

  localparam logic [7:0] UBX_SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] UBX_SYNC_SECOND_RST = 8'd98;

  localparam int unsigned UBX_PADDR_W = 3;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  frame_class;
    logic [7:0]  msg_ident;
    logic [15:0] payload_len;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// File: hw/rtl/ubx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser front end
// Tracks the frame phase, the Fletcher sums and the header fields, and pushes
// one result into the queue for each payload byte and each checksum verdict.
// ----------------------------------------------------------------------------
module ubx_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [7:0]             sync_first_i,
  input  logic [7:0]             sync_second_i,
  output logic                   push_o,
  output ubx_pkg::result_t       push_data_o
);

  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_IDENT   = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  ident_q, ident_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  ck_a_q, ck_a_d;
  logic [7:0]  add_a;
  logic [15:0] count_inc;

  assign add_a     = sum_a_q + rx_byte_i;
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    class_d     = class_q;
    ident_d     = ident_q;
    len_d       = len_q;
    count_d     = count_q;
    ck_a_d      = ck_a_q;
    push_o      = 1'b0;
    push_data_o = '{kind: ubx_pkg::KIND_DATA, frame_class: class_q, msg_ident: ident_q,
                    payload_len: len_q, byte_index: 16'd0, data_byte: 8'd0};
    if (fire_i) begin
      unique case (phase_q)
        PH_SYNC2: begin
          if (rx_byte_i == sync_second_i) begin
            phase_d = PH_CLASS;
            sum_a_d = 8'd0;
            sum_b_d = 8'd0;
          end else if (rx_byte_i == sync_first_i) begin
            phase_d = PH_SYNC2;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          class_d = rx_byte_i;
          sum_a_d = add_a;
          sum_b_d = sum_b_q + add_a;
          phase_d = PH_IDENT;
        end
        PH_IDENT: begin
          ident_d = rx_byte_i;
          sum_a_d = add_a;
          sum_b_d = sum_b_q + add_a;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {8'd0, rx_byte_i};
          sum_a_d = add_a;
          sum_b_d = sum_b_q + add_a;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = {rx_byte_i, len_q[7:0]};
          sum_a_d = add_a;
          sum_b_d = sum_b_q + add_a;
          count_d = 16'd0;
          phase_d = ({rx_byte_i, len_q[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_a_d                = add_a;
          sum_b_d                = sum_b_q + add_a;
          push_o                 = 1'b1;
          push_data_o.byte_index = count_q;
          push_data_o.data_byte  = rx_byte_i;
          count_d                = count_inc;
          if (count_inc == len_q) begin
            phase_d = PH_CK_A;
          end
        end
        PH_CK_A: begin
          ck_a_d  = rx_byte_i;
          phase_d = PH_CK_B;
        end
        PH_CK_B: begin
          push_o           = 1'b1;
          push_data_o.kind = ((ck_a_q == sum_a_q) && (rx_byte_i == sum_b_q)) ?
                             ubx_pkg::KIND_GOOD : ubx_pkg::KIND_BAD;
          phase_d          = PH_SYNC1;
        end
        default: begin
          phase_d = (rx_byte_i == sync_first_i) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      sum_a_q <= 8'd0;
      sum_b_q <= 8'd0;
      class_q <= 8'd0;
      ident_q <= 8'd0;
      len_q   <= 16'd0;
      count_q <= 16'd0;
      ck_a_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      class_q <= class_d;
      ident_q <= ident_d;
      len_q   <= len_d;
      count_q <= count_d;
      ck_a_q  <= ck_a_d;
    end
  end

endmodule

// File: hw/rtl/ubx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX result queue
// Short first-in first-out buffer that decouples the parser from the output.
// ----------------------------------------------------------------------------
module ubx_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ubx_pkg::result_t       push_data_i,
  input  logic                   pop_i,
  output ubx_pkg::result_t       head_o,
  output ubx_pkg::queue_status_t status_o
);

  ubx_pkg::result_t                 mem_q [ubx_pkg::UBX_QDEPTH];
  logic [ubx_pkg::UBX_QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ubx_pkg::UBX_QCNT_W-1:0] count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == ubx_pkg::UBX_QCNT_W'(ubx_pkg::UBX_QDEPTH));

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + ubx_pkg::UBX_QCNT_W'(1);
      2'b01:   count_d = count_q - ubx_pkg::UBX_QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + ubx_pkg::UBX_QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + ubx_pkg::UBX_QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

endmodule

// File: hw/rtl/ubx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX output stage
// Drains the result queue into an output register and presents it to the
// receiver until the transfer completes.
// ----------------------------------------------------------------------------
module ubx_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ubx_pkg::result_t       head_i,
  input  ubx_pkg::queue_status_t status_i,
  output logic                   pop_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output ubx_pkg::result_t       out_data_o
);

  logic             valid_q, valid_d;
  ubx_pkg::result_t data_q;

  assign pop_o       = !status_i.empty && (!valid_q || out_ready_i);
  assign valid_d     = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

endmodule

// File: hw/rtl/ubx_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser
// Finds sync-delimited binary frames in a byte stream and checks their
// 8-bit Fletcher checksum.
// ----------------------------------------------------------------------------
// The input channel carries one received byte per transfer; the output channel
// carries one result per transfer: either a payload byte tagged with class, id,
// length and index, or a frame status (checksum good or bad) after the second
// checksum byte. Bytes that produce no result are simply consumed.
// A byte may be taken on every cycle while the queue is not full. The edge that
// accepts a byte writes its result into a four-entry queue, and the output
// register loads it from there once the register is empty or being drained.
// Throughput is one byte per cycle while the queue has space.
// When the receiver stalls, the queue and output register absorb up to five
// results, after which in_ready_o falls until space frees up.
// The sync byte values are written through the APB port: sync_first at byte
// address 0 and sync_second at byte address 4; they reset to 181 and 98.
// After reset the parser hunts for the first sync byte and no result is held.
// ----------------------------------------------------------------------------
module ubx_frame_parser_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ubx_pkg::UBX_PADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      result_kind_o,
  output logic [7:0]                      frame_class_o,
  output logic [7:0]                      msg_ident_o,
  output logic [15:0]                     payload_len_o,
  output logic [15:0]                     byte_index_o,
  output logic [7:0]                      data_byte_o
);

  logic                   [7:0] sync_first_q, sync_second_q;
  logic                         cfg_wr;
  ubx_pkg::reg_idx_e            cfg_idx;
  logic                         in_fire;
  logic                         push;
  ubx_pkg::result_t             push_data;
  logic                         pop;
  ubx_pkg::result_t             head;
  ubx_pkg::queue_status_t       q_status;
  ubx_pkg::result_t             out_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ubx_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      ubx_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_q};
      default:                  prdata = {24'd0, sync_first_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= ubx_pkg::UBX_SYNC_FIRST_RST;
      sync_second_q <= ubx_pkg::UBX_SYNC_SECOND_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == ubx_pkg::REG_SYNC_FIRST) begin
        sync_first_q <= pwdata[7:0];
      end else begin
        sync_second_q <= pwdata[7:0];
      end
    end
  end

  assign in_ready_o = !q_status.full;
  assign in_fire    = in_valid_i && in_ready_o;

  ubx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .rx_byte_i     (rx_byte_i),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  ubx_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  ubx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign result_kind_o = out_data.kind;
  assign frame_class_o = out_data.frame_class;
  assign msg_ident_o   = out_data.msg_ident;
  assign payload_len_o = out_data.payload_len;
  assign byte_index_o  = out_data.byte_index;
  assign data_byte_o   = out_data.data_byte;

endmodule

// File: hw/rtl/ubx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser checker
// Port-level assertions on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
module ubx_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  result_kind_o,
  input  logic [15:0] payload_len_o,
  input  logic [15:0] byte_index_o,
  input  logic [7:0]  data_byte_o
);

  a_valid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output valid dropped before the transfer.");

  a_payload_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_kind_o) && $stable(byte_index_o)
      && $stable(data_byte_o))
    else $error("Output payload changed while stalled.");

  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != ubx_pkg::KIND_DATA) |->
      (byte_index_o == 16'd0) && (data_byte_o == 8'd0))
    else $error("Status result carries a nonzero index or data byte.");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == ubx_pkg::KIND_DATA) |->
      (byte_index_o < payload_len_o))
    else $error("Payload byte index is not below the frame length.");

endmodule

bind ubx_frame_parser_top ubx_checker u_ubx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .payload_len_o (payload_len_o),
  .byte_index_o  (byte_index_o),
  .data_byte_o   (data_byte_o)
);

// File: tb/tb_ubx_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds byte streams with well-formed, corrupted and broken frames into the
// parser under several sync byte settings. A predictor mirrors the parser
// state and every output transfer is compared with its predicted result.
// ----------------------------------------------------------------------------
module tb_ubx_frame_parser_top;

  localparam int ADDR_W         = ubx_pkg::UBX_PADDR_W;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 50;

  typedef enum logic [3:0] {
    ST_HUNT1, ST_HUNT2, ST_CLASS, ST_IDENT, ST_LEN_LO, ST_LEN_HI,
    ST_PAYLOAD, ST_CK_A, ST_CK_B
  } frame_state_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        result_kind_o;
  logic [7:0]        frame_class_o;
  logic [7:0]        msg_ident_o;
  logic [15:0]       payload_len_o;
  logic [15:0]       byte_index_o;
  logic [7:0]        data_byte_o;

  ubx_frame_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .frame_class_o (frame_class_o),
    .msg_ident_o   (msg_ident_o),
    .payload_len_o (payload_len_o),
    .byte_index_o  (byte_index_o),
    .data_byte_o   (data_byte_o)
  );

  logic [7:0]        cfg_sync_first  = ubx_pkg::UBX_SYNC_FIRST_RST;
  logic [7:0]        cfg_sync_second = ubx_pkg::UBX_SYNC_SECOND_RST;

  frame_state_e      frame_state   = ST_HUNT1;
  logic [15:0]       fletcher_sums = '0;
  logic [7:0]        cur_class     = '0;
  logic [7:0]        cur_ident     = '0;
  logic [15:0]       cur_length    = '0;
  logic [15:0]       payload_pos   = '0;
  logic [7:0]        rx_check_a    = '0;

  logic [7:0]        rx_stream[$];
  ubx_pkg::result_t  parser_results[$];

  int                bytes_queued   = 0;
  int                error_count    = 0;
  int                src_gap_pct    = 0;
  int                sink_stall_pct = 0;
  int                src_wait       = 0;
  int                sink_wait      = 0;
  int                idle_cycles    = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The upper byte holds sum B and the lower byte sum A.
  function automatic logic [15:0] fletcher_next(input logic [15:0] sums, input logic [7:0] x);
    logic [7:0] a;
    logic [7:0] b;
    a = sums[7:0] + x;
    b = sums[15:8] + a;
    return {b, a};
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(0, 3));
    if (r < 90) return 16'($urandom_range(4, 16));
    return 16'($urandom_range(17, 64));
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    ubx_pkg::result_t res;
    bit               emit;
    res  = '0;
    emit = 1'b0;
    case (frame_state)
      ST_HUNT2: begin
        if (b == cfg_sync_second) begin
          frame_state   = ST_CLASS;
          fletcher_sums = '0;
        end else if (b == cfg_sync_first) begin
          frame_state = ST_HUNT2;
        end else begin
          frame_state = ST_HUNT1;
        end
      end
      ST_CLASS: begin
        cur_class     = b;
        fletcher_sums = fletcher_next(fletcher_sums, b);
        frame_state   = ST_IDENT;
      end
      ST_IDENT: begin
        cur_ident     = b;
        fletcher_sums = fletcher_next(fletcher_sums, b);
        frame_state   = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        cur_length    = {8'h00, b};
        fletcher_sums = fletcher_next(fletcher_sums, b);
        frame_state   = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        cur_length    = {b, cur_length[7:0]};
        fletcher_sums = fletcher_next(fletcher_sums, b);
        payload_pos   = '0;
        frame_state   = (cur_length == 16'd0) ? ST_CK_A : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        fletcher_sums  = fletcher_next(fletcher_sums, b);
        res.kind       = ubx_pkg::KIND_DATA;
        res.byte_index = payload_pos;
        res.data_byte  = b;
        emit           = 1'b1;
        payload_pos    = payload_pos + 16'd1;
        if (payload_pos == cur_length) frame_state = ST_CK_A;
      end
      ST_CK_A: begin
        rx_check_a  = b;
        frame_state = ST_CK_B;
      end
      ST_CK_B: begin
        res.kind    = (rx_check_a == fletcher_sums[7:0] && b == fletcher_sums[15:8]) ?
                      ubx_pkg::KIND_GOOD : ubx_pkg::KIND_BAD;
        emit        = 1'b1;
        frame_state = ST_HUNT1;
      end
      default: begin
        frame_state = (b == cfg_sync_first) ? ST_HUNT2 : ST_HUNT1;
      end
    endcase
    if (emit) begin
      res.frame_class = cur_class;
      res.msg_ident   = cur_ident;
      res.payload_len = cur_length;
      parser_results.push_back(res);
    end
  endtask

  task automatic check_result();
    ubx_pkg::result_t want;
    if (parser_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d class %02h index %0d",
                                result_kind_o, frame_class_o, byte_index_o));
      return;
    end
    want = parser_results.pop_front();
    if (result_kind_o !== want.kind)
      report_mismatch($sformatf("result_kind got %0d, expected %0d", result_kind_o, want.kind));
    if (frame_class_o !== want.frame_class)
      report_mismatch($sformatf("frame_class got %02h, expected %02h", frame_class_o,
                                want.frame_class));
    if (msg_ident_o !== want.msg_ident)
      report_mismatch($sformatf("msg_ident got %02h, expected %02h", msg_ident_o,
                                want.msg_ident));
    if (payload_len_o !== want.payload_len)
      report_mismatch($sformatf("payload_len got %0d, expected %0d", payload_len_o,
                                want.payload_len));
    if (byte_index_o !== want.byte_index)
      report_mismatch($sformatf("byte_index got %0d, expected %0d", byte_index_o,
                                want.byte_index));
    if (data_byte_o !== want.data_byte)
      report_mismatch($sformatf("data_byte got %02h, expected %02h", data_byte_o,
                                want.data_byte));
  endtask

  // Input side: one transfer per handshake, with optional random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      src_wait = 0;
    end else begin
      if (in_valid_i && in_ready_o) parse_byte(rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (src_wait > 0) begin
          src_wait--;
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream.pop_front();
          if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct)
            src_wait = pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each transfer and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      if (sink_wait > 0) begin
        sink_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct)
          sink_wait = pick_pause();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_sync_reg(input ubx_pkg::reg_idx_e idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ubx_pkg::REG_SYNC_FIRST) cfg_sync_first = value;
    else cfg_sync_second = value;
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      do b = 8'($urandom_range(0, 255)); while (b == cfg_sync_first);
      push_byte(b);
    end
  endtask

  // A fill below zero gives random payload bytes.
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] ident,
                            input logic [15:0] len, input int fill, input bit corrupt,
                            input bit double_sync, input bit embed_sync);
    logic [15:0] ck;
    logic [7:0]  hdr[4];
    logic [7:0]  b;
    int          i;
    ck  = '0;
    hdr = '{cls, ident, len[7:0], len[15:8]};
    push_byte(cfg_sync_first);
    if (double_sync) push_byte(cfg_sync_first);
    push_byte(cfg_sync_second);
    for (i = 0; i < 4; i++) begin
      push_byte(hdr[i]);
      ck = fletcher_next(ck, hdr[i]);
    end
    for (i = 0; i < int'(len); i++) begin
      if (embed_sync && i < 2) b = (i == 0) ? cfg_sync_first : cfg_sync_second;
      else if (fill >= 0) b = 8'(fill);
      else b = 8'($urandom_range(0, 255));
      push_byte(b);
      ck = fletcher_next(ck, b);
    end
    if (corrupt) ck ^= 16'(1) << $urandom_range(0, 15);
    push_byte(ck[7:0]);
    push_byte(ck[15:8]);
  endtask

  task automatic queue_random_traffic(input int n_items);
    int         target;
    int         r;
    logic [7:0] b;
    bit         may_double;
    target     = bytes_queued + n_items;
    may_double = (cfg_sync_first != cfg_sync_second);
    while (bytes_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_length(),
                   -1, 1'b0, may_double && $urandom_range(0, 9) == 0, 1'b0);
      end else if (r < 78) begin
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_length(),
                   -1, 1'b1, 1'b0, $urandom_range(0, 2) == 0);
      end else if (r < 84) begin
        push_byte(cfg_sync_first);
        do b = 8'($urandom_range(0, 255));
        while (b == cfg_sync_first || b == cfg_sync_second);
        push_byte(b);
      end else if (r < 88) begin
        push_byte(cfg_sync_first);
        push_byte(cfg_sync_second);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(1, 8)));
        push_byte(8'h00);
      end else begin
        push_noise($urandom_range(1, 6));
      end
    end
  endtask

  task automatic wait_idle();
    while (rx_stream.size() != 0 || in_valid_i || parser_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] first, input logic [7:0] second,
                           input int gap_pct, input int stall_pct, input int n_items);
    write_sync_reg(ubx_pkg::REG_SYNC_FIRST, first);
    write_sync_reg(ubx_pkg::REG_SYNC_SECOND, second);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    queue_random_traffic(n_items);
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_gap_pct    = 20;
    sink_stall_pct = 20;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(8'hFF, 8'h00, 16'd1, 8'hFF, 1'b0, 1'b1, 1'b0);
    push_byte(cfg_sync_first);
    push_byte(8'h00);
    push_frame(8'h00, 8'hFF, 16'd0, 0, 1'b1, 1'b0, 1'b0);
    wait_idle();

    run_phase(8'h00, 8'hFF, 30, 30, 160);
    run_phase(8'hFF, 8'h00, 0, 0, 160);
    push_frame(8'h3C, 8'hC3, 16'd300, -1, 1'b0, 1'b0, 1'b0);
    wait_idle();
    run_phase(8'h5A, 8'h5A, 50, 10, 160);
    run_phase(8'h55, 8'hAA, 10, 60, 160);
    run_phase(ubx_pkg::UBX_SYNC_FIRST_RST, ubx_pkg::UBX_SYNC_SECOND_RST, 30, 30, 160);

    // Flush any frame left open, then send a long frame and a short one.
    push_noise(12);
    wait_idle();
    sink_stall_pct = 5;
    src_gap_pct    = 0;
    push_frame(8'hA5, 8'h5A, 16'd260, -1, 1'b0, 1'b0, 1'b0);
    push_frame(8'h01, 8'h07, 16'd4, -1, 1'b0, 1'b0, 1'b0);
    wait_idle();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
